>>> sv/mfi_pkg.sv
// Package for the mesh force interpolation block: widths, controller states,
// command/status structs and the blend step tables. No dependencies.
package mfi_pkg;

    localparam int MESH_DIM_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W         = 20;
    localparam int IDX_W         = 12;
    localparam int POT_W         = 32;
    localparam int ACC_W         = 32;
    localparam int D_W           = POT_W + 1;
    localparam int CRD_W         = 16;
    localparam int ADR_W         = 20;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [3:0] LAST_RD   = 4'd15;
    localparam logic [2:0] LAST_STEP = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_MUL,
        S_ADD,
        S_STORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       rd_en;
        logic       mul;
        logic       add;
        logic       store;
        logic       emit;
        logic [2:0] node;
        logic       side;
        logic [2:0] step;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic oob;
    } t_sts;

    // Node slot holding the lower operand (and result) of each blend step.
    function automatic logic [2:0] step_a(input logic [2:0] step);
        logic [2:0] r;
        case (step)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd0;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd0;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] step_b(input logic [2:0] step);
        logic [2:0] r;
        case (step)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd5;
            3'd3:    r = 3'd7;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd6;
            3'd6:    r = 3'd4;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_f(input logic [2:0] step);
        logic [1:0] r;
        case (step)
            3'd0, 3'd1, 3'd2, 3'd3: r = AX_X;
            3'd4, 3'd5:             r = AX_Y;
            default:                r = AX_Z;
        endcase
        return r;
    endfunction

endpackage

>>> sv/mfi_ctrl.sv
// Controller of the mesh force interpolation block: sequences gather reads,
// blend steps and result strobe. Depends on mfi_pkg.
module mfi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_op,
    input  mfi_pkg::t_sts i_sts,
    output mfi_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import mfi_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_rd, n_rd;
    logic [2:0] r_step, n_step;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= '0;
            r_step  <= '0;
            r_axis  <= AX_X;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
            r_step  <= n_step;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rd    = r_rd;
        n_step  = r_step;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.node = r_rd[3:1];
        o_cmd.side = r_rd[0];
        o_cmd.step = r_step;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_op) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_rd   = '0;
                        n_axis = AX_X;
                        n_state = i_sts.oob ? S_DONE : S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_rd = r_rd + 4'd1;
                if (r_rd == LAST_RD) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_STORE;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_axis == AX_Z) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_rd    = '0;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/mfi_datapath.sv
// Datapath of the mesh force interpolation block: potential memory, node
// difference gather, shared lerp unit and output registers. Depends on mfi_pkg.
module mfi_datapath #(
    parameter int MESH_DIM  = mfi_pkg::MESH_DIM_DEF,
    parameter int FRAC_BITS = mfi_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mfi_pkg::t_cmd                      i_cmd,
    output mfi_pkg::t_sts                      o_sts,
    input  logic [mfi_pkg::IDX_W-1:0]          i_cell_index,
    input  logic signed [mfi_pkg::POT_W-1:0]   i_potential_value,
    input  logic [mfi_pkg::POS_W-1:0]          i_pos_x,
    input  logic [mfi_pkg::POS_W-1:0]          i_pos_y,
    input  logic [mfi_pkg::POS_W-1:0]          i_pos_z,
    output logic                               o_valid,
    output logic signed [mfi_pkg::ACC_W-1:0]   o_accel_x,
    output logic signed [mfi_pkg::ACC_W-1:0]   o_accel_y,
    output logic signed [mfi_pkg::ACC_W-1:0]   o_accel_z,
    output logic                               o_out_of_mesh
);
    import mfi_pkg::*;

    localparam int CELLS     = MESH_DIM * MESH_DIM * MESH_DIM;
    localparam int MEM_DEPTH = (CELLS < (1 << IDX_W)) ? CELLS : (1 << IDX_W);
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int PW        = D_W + FRAC_BITS + 2;
    localparam logic [CRD_W-1:0] EDGE = CRD_W'(MESH_DIM - 1);

    logic [POT_W-1:0]            mem [MEM_DEPTH];
    logic [POT_W-1:0]            r_rd_data;
    logic                        r_rd_vld;
    logic [2:0]                  r_rd_node;
    logic                        r_rd_side;
    logic                        r_rd_border;
    logic [POT_W-1:0]            r_lo;
    logic [FRAC_BITS-1:0]        r_fx, r_fy, r_fz;
    logic [CRD_W-1:0]            r_cx, r_cy, r_cz;
    logic                        r_oob;
    logic signed [D_W-1:0]       r_node [8];
    logic signed [PW-1:0]        r_prod;
    logic signed [ACC_W-1:0]     r_acc [3];
    logic                        r_valid;

    logic [CRD_W-1:0]            cx_in, cy_in, cz_in;
    logic [CRD_W-1:0]            ci, cj, ck, ni, nj, nk, dlt;
    logic                        border;
    logic [ADR_W-1:0]            rd_addr;
    logic signed [D_W-1:0]       lerp_a, lerp_b, lerp_res, sat_src;
    logic signed [D_W:0]         lerp_diff;
    logic [FRAC_BITS-1:0]        lerp_f;
    logic signed [PW-1:0]        rounded, shifted;
    logic signed [D_W:0]         half;
    logic signed [ACC_W-1:0]     sat_val;

    // Cell coordinates straight from the request for the outside check.
    assign cx_in = CRD_W'(i_pos_x[POS_W-1:FRAC_BITS]);
    assign cy_in = CRD_W'(i_pos_y[POS_W-1:FRAC_BITS]);
    assign cz_in = CRD_W'(i_pos_z[POS_W-1:FRAC_BITS]);
    assign o_sts.oob = (cx_in >= EDGE) || (cy_in >= EDGE) || (cz_in >= EDGE);

    // Node coordinates and neighbor address for the current gather read.
    always_comb begin
        ci = r_cx + CRD_W'(i_cmd.node[0]);
        cj = r_cy + CRD_W'(i_cmd.node[1]);
        ck = r_cz + CRD_W'(i_cmd.node[2]);
        border = (ci == '0) || (cj == '0) || (ck == '0) ||
                 (ci >= EDGE) || (cj >= EDGE) || (ck >= EDGE);
        dlt = i_cmd.side ? CRD_W'(1) : {CRD_W{1'b1}};
        ni = ci;
        nj = cj;
        nk = ck;
        case (i_cmd.axis)
            AX_X:    ni = ci + dlt;
            AX_Y:    nj = cj + dlt;
            default: nk = ck + dlt;
        endcase
        rd_addr = (ADR_W'(ni) * ADR_W'(MESH_DIM) + ADR_W'(nj)) * ADR_W'(MESH_DIM)
                  + ADR_W'(nk);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (ADR_W'(i_cell_index) < ADR_W'(CELLS))) begin
            mem[i_cell_index[MEM_AW-1:0]] <= i_potential_value;
        end
        r_rd_data <= mem[rd_addr[MEM_AW-1:0]];
    end

    // Shared lerp unit operands and result, and the saturated store value.
    always_comb begin
        lerp_a = r_node[step_a(i_cmd.step)];
        lerp_b = r_node[step_b(i_cmd.step)];
        case (step_f(i_cmd.step))
            AX_X:    lerp_f = r_fx;
            AX_Y:    lerp_f = r_fy;
            default: lerp_f = r_fz;
        endcase
        lerp_diff = {lerp_b[D_W-1], lerp_b} - {lerp_a[D_W-1], lerp_a};
        rounded   = r_prod + PW'(64'd1 << (FRAC_BITS - 1));
        shifted   = rounded >>> FRAC_BITS;
        lerp_res  = lerp_a + shifted[D_W-1:0];
        sat_src   = r_node[0];
        half      = ($signed({sat_src[D_W-1], sat_src}) + $signed((D_W+1)'(1))) >>> 1;
        if (half > (D_W+1)'(64'sh7FFF_FFFF)) begin
            sat_val = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (half < -(D_W+1)'(64'sh8000_0000)) begin
            sat_val = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sat_val = half[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_valid  <= i_cmd.emit;
        end
        r_rd_node   <= i_cmd.node;
        r_rd_side   <= i_cmd.side;
        r_rd_border <= border;
        if (i_cmd.capture) begin
            r_cx  <= cx_in;
            r_cy  <= cy_in;
            r_cz  <= cz_in;
            r_fx  <= i_pos_x[FRAC_BITS-1:0];
            r_fy  <= i_pos_y[FRAC_BITS-1:0];
            r_fz  <= i_pos_z[FRAC_BITS-1:0];
            r_oob <= o_sts.oob;
        end
        if (r_rd_vld) begin
            if (!r_rd_side) begin
                r_lo <= r_rd_data;
            end else if (r_rd_border) begin
                r_node[r_rd_node] <= '0;
            end else begin
                r_node[r_rd_node] <= $signed({r_lo[POT_W-1], r_lo}) -
                                     $signed({r_rd_data[POT_W-1], r_rd_data});
            end
        end
        if (i_cmd.mul) begin
            r_prod <= lerp_diff * $signed({1'b0, lerp_f});
        end
        if (i_cmd.add) begin
            r_node[step_a(i_cmd.step)] <= lerp_res;
        end
        if (i_cmd.store) begin
            r_acc[i_cmd.axis] <= sat_val;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_of_mesh = r_oob;
    assign o_accel_x     = r_oob ? '0 : r_acc[0];
    assign o_accel_y     = r_oob ? '0 : r_acc[1];
    assign o_accel_z     = r_oob ? '0 : r_acc[2];

endmodule

>>> sv/mesh_force_interpolation_top.sv
// Top level of the mesh force interpolation block: controller plus datapath.
// Depends on mfi_pkg, mfi_ctrl and mfi_datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  request   | start high, busy low | i_op, i_cell_index, i_potential_value, i_pos_*
//  result    | o_valid, one cycle   | o_accel_x/y/z, o_out_of_mesh
//
// A load request writes the mesh in the accepting cycle and keeps busy low.
// A query inside the mesh runs, per axis, 16 reads through the single memory
// read port, a drain state, seven lerps of a multiply and an add state, and
// one store. An outside query skips them. The result strobe follows busy low.
// Reset (synchronous, active low) returns the controller to idle; mesh contents
// stay undefined until written. The receiver cannot stall; results never wait.
module mesh_force_interpolation_top #(
    parameter int MESH_DIM  = mfi_pkg::MESH_DIM_DEF,
    parameter int FRAC_BITS = mfi_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_op,
    input  logic [mfi_pkg::IDX_W-1:0]        i_cell_index,
    input  logic signed [mfi_pkg::POT_W-1:0] i_potential_value,
    input  logic [mfi_pkg::POS_W-1:0]        i_pos_x,
    input  logic [mfi_pkg::POS_W-1:0]        i_pos_y,
    input  logic [mfi_pkg::POS_W-1:0]        i_pos_z,
    output logic                             o_valid,
    output logic signed [mfi_pkg::ACC_W-1:0] o_accel_x,
    output logic signed [mfi_pkg::ACC_W-1:0] o_accel_y,
    output logic signed [mfi_pkg::ACC_W-1:0] o_accel_z,
    output logic                             o_out_of_mesh
);
    import mfi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the request: gather, blend, store, strobe.
    mfi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold the mesh and do the arithmetic.
    mfi_datapath #(
        .MESH_DIM  (MESH_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cell_index      (i_cell_index),
        .i_potential_value (i_potential_value),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .o_valid           (o_valid),
        .o_accel_x         (o_accel_x),
        .o_accel_y         (o_accel_y),
        .o_accel_z         (o_accel_z),
        .o_out_of_mesh     (o_out_of_mesh)
    );

endmodule

>>> sv/mfi_checker.sv
// Port-level checker for the mesh force interpolation block, with its bind.
// Depends on mfi_pkg and mesh_force_interpolation_top.
module mfi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             i_op,
    input logic                             o_valid,
    input logic signed [mfi_pkg::ACC_W-1:0] o_accel_x,
    input logic signed [mfi_pkg::ACC_W-1:0] o_accel_y,
    input logic signed [mfi_pkg::ACC_W-1:0] o_accel_z,
    input logic                             o_out_of_mesh
);
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_mesh |-> (o_accel_x == 0) && (o_accel_y == 0) &&
        (o_accel_z == 0)) else $error("outside query with nonzero result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_op |=> !o_valid) else $error("load produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op |=> busy) else $error("query did not raise busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without preceding work");

endmodule

bind mesh_force_interpolation_top mfi_checker u_mfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .o_accel_x     (o_accel_x),
    .o_accel_y     (o_accel_y),
    .o_accel_z     (o_accel_z),
    .o_out_of_mesh (o_out_of_mesh)
);
